// ----- rtl/core/ptame_pkg.sv -----
// Package for the peer table with aging and master election: codes and request types.
package ptame_pkg;

  // Request operation codes
  localparam logic [1:0] OP_UPDATE    = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_RESET_ALL = 2'd2;
  localparam logic [1:0] OP_RESET_ME  = 2'd3;

  // Entry status codes
  localparam logic [1:0] ST_NEVER   = 2'd0;
  localparam logic [1:0] ST_TIMED   = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MY_ID   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Slot index width inside the scan packet; covers the largest table of 64 entries
  localparam int SLOT_W = 6;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  peer_id;
    logic [7:0]  peer_master;
    logic [7:0]  peer_version;
    logic [15:0] peer_clear;
    logic [9:0]  own_clear;
    logic [31:0] now_ms;
  } ptame_req_t;

  typedef struct packed {
    logic       is_master;
    logic [2:0] slot;
    logic       slot_valid;
  } ptame_rsp_t;

  // Packet that walks the cell row, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic              is_tick;
    logic [7:0]        peer_id;
    logic [31:0]       now_ms;
    logic [9:0]        own_clear;
    logic              done;
    logic [SLOT_W-1:0] sel;
    logic              timed_found;
    logic [SLOT_W-1:0] timed_idx;
    logic              best_valid;
    logic [31:0]       best_age;
    logic [SLOT_W-1:0] best_idx;
    logic              stop;
  } ptame_pkt_t;

  // Slot write broadcast at the end of a peer update scan
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    logic [7:0]        id;
    logic [15:0]       light;
    logic [7:0]        version;
    logic [7:0]        master_byte;
    logic [31:0]       stamp;
  } ptame_wr_t;

endpackage

// ----- rtl/core/peer_table_aging_master_elect.sv -----
// Top level of the peer table with aging and master election.
//
// A request is taken when start is high and busy is low; every request gives
// exactly one response, shown on out_data for the single cycle in which
// out_valid is high, and the receiver cannot hold it off. Reset-all, reset-me
// and a peer update that carries the node's own id answer in the cycle after
// the request and leave busy low, so such requests may follow every cycle.
// A tick and a peer update from another node send a scan packet down a row of
// TABLE_DEPTH-1 slot cells, one cell per cycle; busy stays high until the
// packet leaves the last cell, and the response is registered from that exit,
// so the next request can be taken while the response is shown; the wait is
// set by the length of the cell row. A peer update writes its chosen
// slot in the cycle its packet leaves the last cell. Entry 0 is the node
// itself: its reading for the election is the tick's own sample.
module peer_table_aging_master_elect #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ptame_pkg::ptame_req_t in_data,
  output logic                  out_valid,
  output ptame_pkg::ptame_rsp_t out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [31:0]           cfg_wdata
);
  import ptame_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state_r, state_nxt;
  logic [7:0]  my_id_r;
  logic [31:0] timeout_r;
  logic        master_r, master_nxt;
  ptame_req_t  req_r, req_nxt;
  ptame_pkt_t  inj_r, inj_nxt;
  logic        out_valid_r, out_valid_nxt;
  ptame_rsp_t  out_data_r, out_data_nxt;
  ptame_wr_t   wr;
  logic        accept;
  logic [SLOT_W-1:0] fin_slot;

  ptame_pkt_t chain [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] chain_vld;
  ptame_pkt_t last;

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;

  // Row of slot cells; chain[0] is the injection register
  assign chain[0] = inj_r;
  genvar gi;
  generate
    for (gi = 1; gi < TABLE_DEPTH; gi++) begin : g_cell
      ptame_cell #(.CELL_IDX(gi)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .timeout_ms (timeout_r),
        .wr         (wr),
        .pkt_in     (chain[gi-1]),
        .pkt_out    (chain[gi])
      );
    end
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_vld
      assign chain_vld[gi] = chain[gi].valid;
    end
  endgenerate

  assign last = chain[TABLE_DEPTH-1];

  // Slot choice: matching or empty slot, else first timed out, else oldest
  assign fin_slot = last.done        ? last.sel :
                    last.timed_found ? last.timed_idx : last.best_idx;

  always_comb begin
    state_nxt     = state_r;
    master_nxt    = master_r;
    req_nxt       = req_r;
    inj_nxt       = inj_r;
    inj_nxt.valid = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr            = '0;
    wr.idx        = fin_slot;
    wr.id         = req_r.peer_id;
    wr.light      = req_r.peer_clear;
    wr.version    = req_r.peer_version;
    wr.master_byte = req_r.peer_master;
    wr.stamp      = req_r.now_ms;

    // Finish a scan as its packet leaves the last cell
    if (last.valid) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      if (last.is_tick) begin
        master_nxt   = !last.stop;
        out_data_nxt = '{is_master: !last.stop, slot: 3'd0, slot_valid: 1'b0};
      end else begin
        wr.en        = 1'b1;
        out_data_nxt = '{is_master: master_r, slot: fin_slot[2:0], slot_valid: 1'b1};
      end
    end

    if (accept) begin
      req_nxt = in_data;
      inj_nxt = '{valid: 1'b1, is_tick: (in_data.op == OP_TICK),
                  peer_id: in_data.peer_id, now_ms: in_data.now_ms,
                  own_clear: in_data.own_clear, done: 1'b0, sel: '0,
                  timed_found: 1'b0, timed_idx: '0, best_valid: 1'b0,
                  best_age: '0, best_idx: '0, stop: 1'b0};
      out_data_nxt = '{is_master: master_r, slot: 3'd0, slot_valid: 1'b0};
      case (in_data.op)
        OP_UPDATE: begin
          if (in_data.peer_id == my_id_r) begin
            // own id lands in entry 0: answer at once, no scan
            inj_nxt.valid = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt.slot_valid = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
        OP_TICK: begin
          state_nxt = ST_SCAN;
        end
        OP_RESET_ALL: begin
          inj_nxt.valid = 1'b0;
          master_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt.is_master = 1'b1;
        end
        default: begin
          // reset me: only a matching target id takes effect
          inj_nxt.valid = 1'b0;
          out_valid_nxt = 1'b1;
          if (in_data.peer_id == my_id_r) begin
            master_nxt = 1'b1;
            out_data_nxt.is_master = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      master_r    <= 1'b1;
      my_id_r     <= 8'd0;
      timeout_r   <= 32'd30000;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      master_r    <= master_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MY_ID:   my_id_r   <= cfg_wdata[7:0];
          CFG_TIMEOUT: timeout_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Only one scan packet may be in the row at a time
  a_one_packet: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld))
    else $error("more than one scan packet in the cell row");

  // A packet leaving the row must belong to a running scan
  a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid |-> state_r == ST_SCAN)
    else $error("scan packet left the row while idle");

  // A tick holds off further requests on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == OP_TICK |=> busy && !out_valid)
    else $error("tick did not start a scan");

  // Reset-all answers next cycle as master
  a_reset_all: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.op == OP_RESET_ALL |=> out_valid && out_data.is_master)
    else $error("reset-all did not report master");
`endif

endmodule

// ----- rtl/core/ptame_cell.sv -----
// One peer slot of the table: holds the entry and handles the passing scan packet.
module ptame_cell #(
  parameter int CELL_IDX = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           timeout_ms,
  input  ptame_pkg::ptame_wr_t  wr,
  input  ptame_pkg::ptame_pkt_t pkt_in,
  output ptame_pkg::ptame_pkt_t pkt_out
);
  import ptame_pkg::*;

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

  logic [7:0]  id_r, id_nxt;
  logic [15:0] light_r, light_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  mbyte_r, mbyte_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [1:0]  status_r, status_nxt;
  ptame_pkt_t  pkt_r, pkt_nxt;
  logic [31:0] age;

  assign age = pkt_in.now_ms - stamp_r;

  always_comb begin
    pkt_nxt    = pkt_in;
    id_nxt     = id_r;
    light_nxt  = light_r;
    ver_nxt    = ver_r;
    mbyte_nxt  = mbyte_r;
    stamp_nxt  = stamp_r;
    status_nxt = status_r;
    if (pkt_in.valid) begin
      if (pkt_in.is_tick) begin
        // age this slot, then stop at the first peer brighter than self
        if (!pkt_in.stop) begin
          if (status_r != ST_PRESENT || age > timeout_ms) begin
            light_nxt = '0;
            if (status_r == ST_PRESENT) begin
              status_nxt = ST_TIMED;
            end
          end
          if ({6'd0, pkt_in.own_clear} < light_nxt) begin
            pkt_nxt.stop = 1'b1;
          end
        end
      end else begin
        if (!pkt_in.done && (status_r == ST_NEVER || id_r == pkt_in.peer_id)) begin
          pkt_nxt.done = 1'b1;
          pkt_nxt.sel  = MY_IDX;
        end
        if (!pkt_in.timed_found && status_r == ST_TIMED) begin
          pkt_nxt.timed_found = 1'b1;
          pkt_nxt.timed_idx   = MY_IDX;
        end
        if (!pkt_in.best_valid || age > pkt_in.best_age) begin
          pkt_nxt.best_valid = 1'b1;
          pkt_nxt.best_age   = age;
          pkt_nxt.best_idx   = MY_IDX;
        end
      end
    end
    if (wr.en && wr.idx == MY_IDX) begin
      id_nxt     = wr.id;
      light_nxt  = wr.light;
      ver_nxt    = wr.version;
      mbyte_nxt  = wr.master_byte;
      stamp_nxt  = wr.stamp;
      status_nxt = ST_PRESENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_NEVER;
      pkt_r    <= '0;
    end else begin
      status_r <= status_nxt;
      pkt_r    <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    light_r <= light_nxt;
    ver_r   <= ver_nxt;
    mbyte_r <= mbyte_nxt;
    stamp_r <= stamp_nxt;
  end

  assign pkt_out = pkt_r;

endmodule
